### sv/field_packet_assembler_crc16_assert.svh
// Assertion macros for the packet assembler blocks.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef FIELD_PACKET_ASSEMBLER_CRC16_ASSERT_SVH
`define FIELD_PACKET_ASSEMBLER_CRC16_ASSERT_SVH

// Same-cycle implication or invariant, checked out of reset.
`define FPA_CRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Condition now implies a result on the next edge.
`define FPA_CRC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: next-cycle assertion failed");

`endif

### sv/fpa_crc_pkg.sv
// Shared constants, types and the CRC16-Modbus byte step for the packet assembler.
// No dependencies.
package fpa_crc_pkg;

  localparam int unsigned BufferBytes = 32;
  localparam int unsigned AddrW       = $clog2(BufferBytes);
  localparam int unsigned LenW        = $clog2(BufferBytes + 1);

  localparam int unsigned CmdW  = 2;
  localparam int unsigned OffW  = 5;
  localparam int unsigned SizeW = 6;
  localparam int unsigned EncW  = 3;
  localparam int unsigned ValW  = 64;
  localparam int unsigned SumW  = SizeW + 1;

  localparam int unsigned MaxLanes = ValW / 8;
  localparam int unsigned NbW      = $clog2(MaxLanes + 1);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [CmdW-1:0] {
    CmdWrite = 2'd0,
    CmdEmit  = 2'd1,
    CmdClear = 2'd2
  } cmd_e;

  typedef enum logic [EncW-1:0] {
    EncByte    = 3'd0,
    EncU16Le   = 3'd1,
    EncU16Be   = 3'd2,
    EncU32Le   = 3'd3,
    EncU32Be   = 3'd4,
    EncGeneric = 3'd5
  } enc_e;

  // Decoded operation: data[i] lands at offset + i for i < nbytes, if inside the store
  typedef struct packed {
    cmd_e                       op;
    logic [OffW-1:0]            offset;
    logic [NbW-1:0]             nbytes;
    logic [MaxLanes-1:0][7:0]   data;
    logic [LenW-1:0]            end_pos;
  } entry_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

### sv/fpa_crc_if.sv
// Handshake interfaces for the packet assembler: item input, byte output, config.
// Depends on fpa_crc_pkg.
interface fpa_crc_in_if;
  logic                           valid;
  logic                           ready;
  logic [fpa_crc_pkg::CmdW-1:0]   command;
  logic [fpa_crc_pkg::OffW-1:0]   field_offset;
  logic [fpa_crc_pkg::SizeW-1:0]  field_size;
  logic [fpa_crc_pkg::EncW-1:0]   encoding;
  logic [fpa_crc_pkg::ValW-1:0]   field_value;

  modport source (output valid, command, field_offset, field_size, encoding, field_value,
                  input ready);
  modport sink   (input valid, command, field_offset, field_size, encoding, field_value,
                  output ready);
endinterface

interface fpa_crc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       empty_packet;

  modport source (output valid, out_byte, last_byte, empty_packet, input ready);
  modport sink   (input valid, out_byte, last_byte, empty_packet, output ready);
endinterface

interface fpa_crc_cfg_if;
  logic valid;
  logic ready;
  logic crc_enable;

  modport source (output valid, crc_enable, input ready);
  modport sink   (input valid, crc_enable, output ready);
endinterface

### sv/fpa_crc_front.sv
// Front end: takes input words and decodes them into byte-lane queue entries.
// Depends on fpa_crc_pkg and fpa_crc_in_if.
module fpa_crc_front (
  fpa_crc_in_if.sink            in_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output fpa_crc_pkg::entry_t   push_entry_o
);
  import fpa_crc_pkg::*;

  logic [SumW-1:0] sum;
  logic [SumW-1:0] pos_hi;

  assign in_i.ready = push_ready_i;

  always_comb begin
    sum    = SumW'(in_i.field_offset) + SumW'(in_i.field_size);
    pos_hi = SumW'(in_i.field_offset) + SumW'(1);

    push_entry_o.offset  = in_i.field_offset;
    push_entry_o.end_pos = (sum > SumW'(BufferBytes)) ? LenW'(BufferBytes) : LenW'(sum);
    push_entry_o.nbytes  = '0;
    for (int i = 0; i < MaxLanes; i++) begin
      push_entry_o.data[i] = in_i.field_value[8*i +: 8];
    end

    push_valid_o = in_i.valid;
    case (in_i.command)
      CmdWrite: push_entry_o.op = CmdWrite;
      CmdEmit:  push_entry_o.op = CmdEmit;
      CmdClear: push_entry_o.op = CmdClear;
      default: begin
        // unused command code: swallowed here
        push_entry_o.op = CmdWrite;
        push_valid_o    = 1'b0;
      end
    endcase

    case (in_i.encoding)
      EncByte: push_entry_o.nbytes = NbW'(1);
      EncU16Le: begin
        if (pos_hi < SumW'(BufferBytes)) push_entry_o.nbytes = NbW'(2);
      end
      EncU16Be: begin
        if (pos_hi < SumW'(BufferBytes)) push_entry_o.nbytes = NbW'(2);
        push_entry_o.data[0] = in_i.field_value[15:8];
        push_entry_o.data[1] = in_i.field_value[7:0];
      end
      EncU32Le: push_entry_o.nbytes = NbW'(4);
      EncU32Be: begin
        push_entry_o.nbytes = NbW'(4);
        for (int i = 0; i < 4; i++) begin
          push_entry_o.data[i] = in_i.field_value[8*(3-i) +: 8];
        end
      end
      default: begin
        push_entry_o.nbytes = (in_i.field_size < SizeW'(MaxLanes))
                            ? NbW'(in_i.field_size) : NbW'(MaxLanes);
      end
    endcase
  end

endmodule

### sv/fpa_crc_queue.sv
// Short FIFO between the decoding front end and the executing back end.
// Depends on fpa_crc_pkg.
module fpa_crc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  fpa_crc_pkg::entry_t   push_entry_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output fpa_crc_pkg::entry_t   pop_entry_o
);
  import fpa_crc_pkg::*;

  entry_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop)      count_d = count_q + QCntW'(1);
    else if (do_pop && !do_push) count_d = count_q - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

### sv/fpa_crc_back.sv
// Back end: packet store, length, CRC enable, byte streamer with output register.
// Depends on fpa_crc_pkg, fpa_crc_if and the assertion macro header.
`include "field_packet_assembler_crc16_assert.svh"

module fpa_crc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fpa_crc_cfg_if.sink           cfg_i,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  fpa_crc_pkg::entry_t   pop_entry_i,
  fpa_crc_out_if.source         out_o
);
  import fpa_crc_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StStream = 4'b0010,
    StCrcLo  = 4'b0100,
    StCrcHi  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [7:0]        store_q [BufferBytes];
  logic [7:0]        store_d [BufferBytes];
  logic [LenW-1:0]   len_q, len_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [15:0]       crc_q, crc_d;
  logic              crc_en_q, crc_en_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              out_empty_q, out_empty_d;

  logic              out_free;
  logic [7:0]        rd_byte;
  logic [15:0]       crc_next;
  logic [OffW:0]     pos;

  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.last_byte    = out_last_q;
  assign out_o.empty_packet = out_empty_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign rd_byte  = store_q[idx_q];
  assign crc_next = crc16_byte(crc_q, rd_byte);

  always_comb begin
    state_d     = state_q;
    store_d     = store_q;
    len_d       = len_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    crc_en_d    = (cfg_i.valid && cfg_i.ready) ? cfg_i.crc_enable : crc_en_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    pop_ready_o = 1'b0;
    pos         = '0;

    case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          case (pop_entry_i.op)
            CmdWrite: begin
              pop_ready_o = 1'b1;
              for (int i = 0; i < MaxLanes; i++) begin
                pos = (OffW+1)'(pop_entry_i.offset) + (OffW+1)'(i);
                // lanes past capacity match no entry and drop out
                for (int j = 0; j < BufferBytes; j++) begin
                  if ((NbW'(i) < pop_entry_i.nbytes) && (pos == (OffW+1)'(j))) begin
                    store_d[j] = pop_entry_i.data[i];
                  end
                end
              end
              if (pop_entry_i.end_pos > len_q) len_d = pop_entry_i.end_pos;
            end
            CmdClear: begin
              pop_ready_o = 1'b1;
              for (int j = 0; j < BufferBytes; j++) store_d[j] = '0;
              len_d = '0;
            end
            CmdEmit: begin
              if (len_q == '0) begin
                if (out_free) begin
                  pop_ready_o = 1'b1;
                  out_valid_d = 1'b1;
                  out_byte_d  = '0;
                  out_last_d  = 1'b1;
                  out_empty_d = 1'b1;
                end
              end else begin
                pop_ready_o = 1'b1;
                idx_d       = '0;
                crc_d       = CrcInit;
                state_d     = StStream;
              end
            end
            default: pop_ready_o = 1'b1;
          endcase
        end
      end
      StStream: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = rd_byte;
          out_empty_d = 1'b0;
          crc_d       = crc_next;
          if ((LenW'(idx_q) + LenW'(1)) == len_q) begin
            out_last_d = !crc_en_q;
            state_d    = crc_en_q ? StCrcLo : StIdle;
          end else begin
            out_last_d = 1'b0;
            idx_d      = idx_q + AddrW'(1);
          end
        end
      end
      StCrcLo: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = crc_q[7:0];
          out_last_d  = 1'b0;
          out_empty_d = 1'b0;
          state_d     = StCrcHi;
        end
      end
      StCrcHi: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = crc_q[15:8];
          out_last_d  = 1'b1;
          out_empty_d = 1'b0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      crc_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < BufferBytes; j++) store_q[j] <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      crc_en_q    <= crc_en_d;
      out_valid_q <= out_valid_d;
      store_q     <= store_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    crc_q       <= crc_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  `FPA_CRC_ASSERT(a_idx_in_len, (state_q == StStream) |-> (LenW'(idx_q) < len_q))
  `FPA_CRC_ASSERT(a_len_cap, len_q <= LenW'(BufferBytes))
  `FPA_CRC_ASSERT(a_pop_idle, pop_ready_o |-> (state_q == StIdle))
  `FPA_CRC_ASSERT(a_empty_word, (out_valid_q && out_empty_q) |-> (out_last_q && (out_byte_q == 8'd0)))
  `FPA_CRC_ASSERT_NEXT(a_crc_hi_last, (state_q == StCrcHi) && out_free, out_valid_q && out_last_q && (state_q == StIdle))

endmodule

### sv/field_packet_assembler_crc16.sv
// Channel | dir | handshake   | word
// in_i    | in  | valid/ready | command, field_offset, field_size, encoding, field_value
// out_o   | out | valid/ready | out_byte, last_byte, empty_packet
// cfg_i   | in  | valid/ready | crc_enable (always ready)
//
// Write and clear words execute in the idle back end; an emit starts the streamer, which sends
// the packet bytes, then the two CRC trailer bytes if enabled, via the single store read port.
// An empty emit gives a single flagged word.
// Reset (rst_ni low, async) zeroes the store, length and CRC enable; no clearing pass.
// A two-word queue parts the front from the back; the output register frees its slot on take.
// Depends on fpa_crc_pkg, fpa_crc_if, fpa_crc_front, fpa_crc_queue, fpa_crc_back.
module field_packet_assembler_crc16 (
  input  logic           clk_i,
  input  logic           rst_ni,
  fpa_crc_in_if.sink     in_i,
  fpa_crc_out_if.source  out_o,
  fpa_crc_cfg_if.sink    cfg_i
);
  import fpa_crc_pkg::*;

  logic    push_valid, push_ready;
  entry_t  push_entry;
  logic    pop_valid, pop_ready;
  entry_t  pop_entry;

  fpa_crc_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  fpa_crc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  fpa_crc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_o       (out_o)
  );

endmodule

### tb/tb_field_packet_assembler_crc16.sv
`timescale 1ns / 1ps
// Self-checking bench for field_packet_assembler_crc16: field writes, emits and clears are
// scored byte by byte against a local model of the packet store and the CRC16 trailer.
// Depends on fpa_crc_pkg, fpa_crc_if and the assembler RTL.
module tb_field_packet_assembler_crc16;
  import fpa_crc_pkg::*;

  localparam int unsigned ClkHalf      = 4;
  localparam int unsigned ResetCycles  = 8;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned MaxPrinted   = 40;

  localparam logic [CmdW-1:0] CmdSpare  = 2'd3;
  localparam logic [EncW-1:0] EncSpare6 = 3'd6;
  localparam logic [EncW-1:0] EncSpare7 = 3'd7;

  typedef struct {
    logic [CmdW-1:0]  command;
    logic [OffW-1:0]  offset;
    logic [SizeW-1:0] size;
    logic [EncW-1:0]  enc;
    logic [ValW-1:0]  value;
  } field_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } tx_byte_t;

  logic clk;
  logic rst_n;

  fpa_crc_in_if  in_if ();
  fpa_crc_out_if out_if ();
  fpa_crc_cfg_if cfg_if ();

  field_packet_assembler_crc16 dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  field_word_t pending_words[$];
  tx_byte_t    expected_tx[$];

  logic [7:0]  model_store [BufferBytes];
  int unsigned model_len;
  logic        crc_on;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        out_hold;
  logic        hold_go;
  int unsigned mismatch_count;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted)
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  function automatic logic [15:0] crc_modbus_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  // bytes past capacity are simply lost
  function automatic void store_byte(int unsigned pos, logic [7:0] b);
    if (pos < BufferBytes) model_store[pos] = b;
  endfunction

  function automatic void expect_byte(logic [7:0] data, logic last, logic empty);
    tx_byte_t t;
    t.data  = data;
    t.last  = last;
    t.empty = empty;
    expected_tx.push_back(t);
  endfunction

  // Updates the packet model for one accepted word and queues the bytes it sends.
  function automatic void apply_field_word(field_word_t w);
    int unsigned off;
    int unsigned sz;
    int unsigned n;
    int unsigned end_pos;
    logic [15:0] crc;
    off = w.offset;
    sz  = w.size;
    case (w.command)
      CmdWrite: begin
        case (w.enc)
          EncByte: store_byte(off, w.value[7:0]);
          EncU16Le: begin
            if (off + 1 < BufferBytes) begin
              store_byte(off, w.value[7:0]);
              store_byte(off + 1, w.value[15:8]);
            end
          end
          EncU16Be: begin
            if (off + 1 < BufferBytes) begin
              store_byte(off, w.value[15:8]);
              store_byte(off + 1, w.value[7:0]);
            end
          end
          EncU32Le: for (int i = 0; i < 4; i++) store_byte(off + i, w.value[8*i +: 8]);
          EncU32Be: for (int i = 0; i < 4; i++) store_byte(off + i, w.value[8*(3-i) +: 8]);
          default: begin
            // generic and the spare codes: up to eight bytes, LSB first
            n = (sz < 8) ? sz : 8;
            for (int i = 0; i < n; i++) store_byte(off + i, w.value[8*i +: 8]);
          end
        endcase
        end_pos = off + sz;
        if (end_pos > BufferBytes) end_pos = BufferBytes;
        if (end_pos > model_len) model_len = end_pos;
      end
      CmdEmit: begin
        if (model_len == 0) begin
          expect_byte(8'h00, 1'b1, 1'b1);
        end else begin
          crc = CrcInit;
          for (int i = 0; i < model_len; i++) begin
            crc = crc_modbus_step(crc, model_store[i]);
            expect_byte(model_store[i], !crc_on && (i == model_len - 1), 1'b0);
          end
          if (crc_on) begin
            expect_byte(crc[7:0], 1'b0, 1'b0);
            expect_byte(crc[15:8], 1'b1, 1'b0);
          end
        end
      end
      CmdClear: begin
        foreach (model_store[i]) model_store[i] = 8'h00;
        model_len = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic field_word_t random_word();
    field_word_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70)      w.command = CmdWrite;
    else if (pick < 90) w.command = CmdEmit;
    else if (pick < 97) w.command = CmdClear;
    else                w.command = CmdSpare;
    // bias some fields onto the top of the store to hit the drop cases
    w.offset = ($urandom_range(99) < 20) ? OffW'($urandom_range(31, 26))
                                         : OffW'($urandom_range(31));
    w.size   = ($urandom_range(99) < 70) ? SizeW'($urandom_range(8))
                                         : SizeW'($urandom_range(32));
    w.enc    = EncW'($urandom_range(7));
    pick = $urandom_range(9);
    if (pick == 0)      w.value = '0;
    else if (pick == 1) w.value = '1;
    else                w.value = {$urandom, $urandom};
    return w;
  endfunction

  task automatic push_word(input logic [CmdW-1:0] cmd, input logic [OffW-1:0] off,
                           input logic [SizeW-1:0] sz, input logic [EncW-1:0] enc,
                           input logic [ValW-1:0] value);
    field_word_t w;
    w.command = cmd;
    w.offset  = off;
    w.size    = sz;
    w.enc     = enc;
    w.value   = value;
    pending_words.push_back(w);
  endtask

  task automatic fill_random(input int unsigned count);
    repeat (count) pending_words.push_back(random_word());
  endtask

  // writes and clears send nothing, so give the back end time to finish after the last byte
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_if.valid || expected_tx.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_crc_enable(input logic en);
    @(posedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.crc_enable <= en;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    crc_on = en;
  endtask

  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin : drive_words
    field_word_t next_word;
    if (!rst_n) begin
      in_if.valid        <= 1'b0;
      in_if.command      <= '0;
      in_if.field_offset <= '0;
      in_if.field_size   <= '0;
      in_if.encoding     <= '0;
      in_if.field_value  <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        apply_field_word('{in_if.command, in_if.field_offset, in_if.field_size,
                           in_if.encoding, in_if.field_value});
      if (!in_if.valid || in_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          in_if.valid        <= 1'b1;
          in_if.command      <= next_word.command;
          in_if.field_offset <= next_word.offset;
          in_if.field_size   <= next_word.size;
          in_if.encoding     <= next_word.enc;
          in_if.field_value  <= next_word.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : score_bytes
    tx_byte_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_tx.size() == 0) begin
          report_mismatch("word with nothing pending, out_byte", out_if.out_byte, 0);
        end else begin
          want = expected_tx.pop_front();
          if (out_if.out_byte !== want.data)
            report_mismatch("out_byte", out_if.out_byte, want.data);
          if (out_if.last_byte !== want.last)
            report_mismatch("last_byte", out_if.last_byte, want.last);
          if (out_if.empty_packet !== want.empty)
            report_mismatch("empty_packet", out_if.empty_packet, want.empty);
        end
      end
      out_if.ready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall so the input queue fills and back-pressures the sender
  initial begin : receiver_hold_off
    wait (hold_go === 1'b1);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    out_hold <= 1'b0;
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst_n              = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.crc_enable  = 1'b0;
    out_hold           = 1'b0;
    hold_go            = 1'b0;
    send_idle_pct      = 9;
    recv_idle_pct      = 53;
    mismatch_count     = 0;
    foreach (model_store[i]) model_store[i] = 8'h00;
    model_len = 0;
    crc_on    = 1'b0;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    write_crc_enable(1'b1);
    // empty emit with the trailer on: still a single flagged word
    push_word(CmdEmit, 5'd0, 6'd0, EncByte, '0);
    push_word(CmdWrite, 5'd0, 6'd1, EncByte, '1);
    push_word(CmdWrite, 5'd1, 6'd2, EncU16Le, 64'h0123_4567_89AB_CDEF);
    push_word(CmdWrite, 5'd3, 6'd2, EncU16Be, 64'h0123_4567_89AB_CDEF);
    push_word(CmdWrite, 5'd5, 6'd4, EncU32Le, 64'hDEAD_BEEF_CAFE_F00D);
    // size 0 on a fixed encoding: bytes land beyond the packet end
    push_word(CmdWrite, 5'd9, 6'd0, EncU32Be, 64'hDEAD_BEEF_CAFE_F00D);
    push_word(CmdEmit, 5'd0, 6'd0, EncByte, '0);
    push_word(CmdWrite, 5'd13, 6'd0, EncGeneric, '1);
    push_word(CmdWrite, 5'd14, 6'd3, EncGeneric, 64'hA5A5_A5A5_A5A5_A5A5);
    push_word(CmdWrite, 5'd17, 6'd12, EncSpare6, 64'h0011_2233_4455_6677);
    push_word(CmdWrite, 5'd29, 6'd2, EncSpare7, '1);
    // 16-bit at the last byte: nothing written, length still grows
    push_word(CmdWrite, 5'd31, 6'd1, EncU16Le, 64'h5A5A);
    push_word(CmdWrite, 5'd31, 6'd0, EncU16Be, 64'h5A5A);
    push_word(CmdWrite, 5'd29, 6'd4, EncU32Le, 64'h8877_6655_4433_2211);
    push_word(CmdEmit, 5'd0, 6'd0, EncByte, '0);
    push_word(CmdSpare, 5'd31, 6'd32, EncGeneric, '1);
    push_word(CmdWrite, 5'd31, 6'd32, EncGeneric, '0);
    push_word(CmdEmit, 5'd0, 6'd0, EncByte, '0);
    push_word(CmdClear, 5'd0, 6'd0, EncByte, '0);
    push_word(CmdEmit, 5'd0, 6'd0, EncByte, '0);
    wait_idle();

    write_crc_enable(1'b0);
    push_word(CmdWrite, 5'd0, 6'd4, EncU32Be, 64'h0000_0000_8000_0001);
    push_word(CmdEmit, 5'd0, 6'd0, EncByte, '0);
    push_word(CmdEmit, 5'd0, 6'd0, EncByte, '0);
    push_word(CmdClear, 5'd0, 6'd0, EncByte, '0);
    push_word(CmdEmit, 5'd0, 6'd0, EncByte, '0);
    wait_idle();

    write_crc_enable(1'b1);
    fill_random(100);
    wait_idle();

    send_idle_pct <= 53;
    recv_idle_pct <= 9;
    write_crc_enable(1'b0);
    fill_random(100);
    wait_idle();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_crc_enable(1'b1);
    // long packet emits queued up behind the stall
    push_word(CmdWrite, 5'd0, 6'd24, EncGeneric, {$urandom, $urandom});
    push_word(CmdEmit, 5'd0, 6'd0, EncByte, '0);
    push_word(CmdEmit, 5'd0, 6'd0, EncByte, '0);
    push_word(CmdEmit, 5'd0, 6'd0, EncByte, '0);
    hold_go <= 1'b1;
    fill_random(81);
    wait_idle();

    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
